/* src/brle_pkg.sv */
package brle_pkg;

  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 29;
  localparam int OUT_CNT_W       = 3;
  localparam int HDR_W           = 3;
  localparam int LITERAL_MAX_DEF = 128;

  localparam logic [CNT_W-1:0] RUN_CAP  = 29'd520093695;
  localparam logic [CNT_W-1:0] RUN_LIM1 = 29'd32;
  localparam logic [CNT_W-1:0] RUN_LIM2 = 29'd8192;
  localparam logic [CNT_W-1:0] RUN_LIM3 = 29'd2097152;

  localparam logic [BYTE_W-1:0] RUN_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] RUN_MASK5 = 8'h1f;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } beat_t;

  // Number of header bytes for a run with the given extra count.
  function automatic logic [HDR_W-1:0] run_hdr_len(input logic [CNT_W-1:0] cnt);
    logic [HDR_W-1:0] len;
    if (cnt < RUN_LIM1) begin
      len = 3'd1;
    end else if (cnt < RUN_LIM2) begin
      len = 3'd2;
    end else if (cnt < RUN_LIM3) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Header byte with rem bytes of the header still to go (rem counts this one).
  function automatic logic [BYTE_W-1:0] run_hdr_byte(input logic [CNT_W-1:0] cnt,
                                                     input logic [HDR_W-1:0] len,
                                                     input logic [HDR_W-1:0] rem);
    logic [BYTE_W-1:0] sel;
    logic [1:0]        sh;
    logic [BYTE_W-1:0] res;
    sh = 2'(rem - 3'd1);
    case (sh)
      2'd0:    sel = cnt[7:0];
      2'd1:    sel = cnt[15:8];
      2'd2:    sel = cnt[23:16];
      default: sel = {3'b000, cnt[28:24]};
    endcase
    if (rem == len) begin
      res = RUN_TAG | {1'b0, 2'(len - 3'd1), 5'b00000} | (sel & RUN_MASK5);
    end else begin
      res = sel;
    end
    return res;
  endfunction

endpackage

/* src/brle_if.sv */
interface brle_in_if;
  logic                         valid;
  logic                         ready;
  logic [brle_pkg::BYTE_W-1:0]  data_byte;
  logic                         final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface brle_out_if;
  logic                            valid;
  logic                            ready;
  logic [brle_pkg::BYTE_W-1:0]     out_byte_a;
  logic [brle_pkg::BYTE_W-1:0]     out_byte_b;
  logic [brle_pkg::BYTE_W-1:0]     out_byte_c;
  logic [brle_pkg::BYTE_W-1:0]     out_byte_d;
  logic [brle_pkg::OUT_CNT_W-1:0]  byte_count;
  logic                            last_of_step;
  logic                            stream_done;

  modport source (output valid, out_byte_a, out_byte_b, out_byte_c, out_byte_d,
                  byte_count, last_of_step, stream_done, input ready);
  modport sink   (input valid, out_byte_a, out_byte_b, out_byte_c, out_byte_d,
                  byte_count, last_of_step, stream_done, output ready);
endinterface

/* src/byte_run_length_encoder_unit.sv */
// Byte run-length encoder: literal headers as in PackBits, runs with their own one- to four-byte headers.
// in_ch takes one raw byte per item with final_byte marking the end of a stream.
// out_ch gives coded bytes packed up to four per item, with byte_count,
// last_of_step on the last item an input caused and stream_done on the last
// item of the stream. Both channels use valid/ready; an item moves when both
// are high.
// An input that codes nothing is taken with in_ch.ready staying high. An input
// that causes N coded bytes holds in_ch.ready low while the bytes go out one per
// cycle, set by the single byte-wide read port of the literal store; the packer
// pauses the bytes after every four while it moves a full item on, and out_ch
// stalls hold them too. The first result item is valid once min(N, 4) bytes
// have reached the packer and moved to its output register.
// Reset clears the segment state and all handshakes; the literal store is not
// cleared and needs no clearing pass.
// When out_ch stalls, one item waits in the output register and one in the
// packer; after that the byte sequencer halts at its next coded byte and in_ch.ready stays low.
module byte_run_length_encoder_unit #(
  parameter int LITERAL_MAX = brle_pkg::LITERAL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  brle_in_if.sink    in_ch,
  brle_out_if.source out_ch
);

  localparam int AW    = $clog2(LITERAL_MAX);
  localparam int LEN_W = $clog2(LITERAL_MAX + 1);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [brle_pkg::BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [brle_pkg::BYTE_W-1:0] mem_rdata;
  logic                        beat_valid;
  logic                        beat_ready;
  brle_pkg::beat_t             beat;

  brle_ctrl #(
    .LITERAL_MAX (LITERAL_MAX),
    .AW          (AW),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  brle_lit_mem #(
    .DEPTH (LITERAL_MAX),
    .AW    (AW)
  ) u_lit_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  brle_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .out_ch     (out_ch)
  );

  // no new input while coded bytes of the previous one are still in flight
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    beat_valid |-> !in_ch.ready)
    else $error("input taken while coded bytes pending");

  // a short item can only close a step
  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.byte_count != 3'd4) |-> out_ch.last_of_step)
    else $error("partial item in the middle of a step");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stream_done) |-> out_ch.last_of_step)
    else $error("stream_done without last_of_step");

  // a byte marked done must carry the last flag into the packer
  a_beat_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_valid && beat.done) |-> beat.last)
    else $error("done byte not marked last");

endmodule

/* src/brle_lit_mem.sv */
module brle_lit_mem #(
  parameter int DEPTH = brle_pkg::LITERAL_MAX_DEF,
  parameter int AW    = $clog2(brle_pkg::LITERAL_MAX_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [brle_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [brle_pkg::BYTE_W-1:0] rd_data
);

  logic [brle_pkg::BYTE_W-1:0] lit_store_r [DEPTH];
  logic [brle_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lit_store_r[wr_addr] <= wr_data;
    end
    rd_data_r <= lit_store_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/brle_packer.sv */
module brle_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat_valid,
  input  brle_pkg::beat_t   beat,
  output logic              beat_ready,
  brle_out_if.source        out_ch
);

  logic [brle_pkg::BYTE_W-1:0]    acc_r [4];
  logic [brle_pkg::BYTE_W-1:0]    acc_nxt [4];
  logic [brle_pkg::OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           pend_r, pend_nxt;
  logic                           last_r, last_nxt;
  logic                           done_r, done_nxt;

  logic                           ov_r, ov_nxt;
  logic [brle_pkg::BYTE_W-1:0]    oa_r, oa_nxt, ob_r, ob_nxt, oc_r, oc_nxt, od_r, od_nxt;
  logic [brle_pkg::OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                           olast_r, olast_nxt;
  logic                           odone_r, odone_nxt;

  logic bfire;
  logic xfer;

  assign beat_ready = !pend_r;
  assign bfire      = beat_valid && beat_ready;
  assign xfer       = pend_r && (!ov_r || out_ch.ready);

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    ov_nxt    = ov_r;
    oa_nxt    = oa_r;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    od_nxt    = od_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    if (bfire) begin
      acc_nxt[cnt_r[1:0]] = beat.data;
      cnt_nxt             = cnt_r + 3'd1;
      last_nxt            = beat.last;
      done_nxt            = beat.done;
      if (cnt_r == 3'd3 || beat.last) begin
        pend_nxt = 1'b1;
      end
    end

    // move a finished item to the output register, zero the unused bytes
    if (xfer) begin
      ov_nxt    = 1'b1;
      oa_nxt    = acc_r[0];
      ob_nxt    = (cnt_r >= 3'd2) ? acc_r[1] : '0;
      oc_nxt    = (cnt_r >= 3'd3) ? acc_r[2] : '0;
      od_nxt    = (cnt_r == 3'd4) ? acc_r[3] : '0;
      ocnt_nxt  = cnt_r;
      olast_nxt = last_r;
      odone_nxt = done_r;
      cnt_nxt   = '0;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
    acc_r   <= acc_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
    oa_r    <= oa_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
    od_r    <= od_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_byte_a   = oa_r;
  assign out_ch.out_byte_b   = ob_r;
  assign out_ch.out_byte_c   = oc_r;
  assign out_ch.out_byte_d   = od_r;
  assign out_ch.byte_count   = ocnt_r;
  assign out_ch.last_of_step = olast_r;
  assign out_ch.stream_done  = odone_r;

endmodule

/* src/brle_ctrl.sv */
module brle_ctrl #(
  parameter int LITERAL_MAX = brle_pkg::LITERAL_MAX_DEF,
  parameter int AW          = $clog2(brle_pkg::LITERAL_MAX_DEF),
  parameter int LEN_W       = $clog2(brle_pkg::LITERAL_MAX_DEF + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brle_in_if.sink                     in_ch,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [brle_pkg::BYTE_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [brle_pkg::BYTE_W-1:0] mem_rdata,
  output logic                        beat_valid,
  output brle_pkg::beat_t             beat,
  input  logic                        beat_ready
);

  typedef enum logic [1:0] {MODE_EMPTY, MODE_LIT, MODE_RUN} mode_t;
  typedef enum logic [2:0] {S_IDLE, S_LIT_HDR, S_LIT_BODY, S_RUN_HDR, S_RUN_VAL} emit_state_t;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LITERAL_MAX);

  // coder state
  mode_t                              mode_r, mode_nxt;
  logic [LEN_W-1:0]                   lit_len_r, lit_len_nxt;
  logic [brle_pkg::BYTE_W-1:0]        lit_last_r, lit_last_nxt;
  logic [brle_pkg::BYTE_W-1:0]        run_val_r, run_val_nxt;
  logic [brle_pkg::CNT_W-1:0]         run_cnt_r, run_cnt_nxt;

  // emitter state
  emit_state_t                        st_r, st_nxt;
  logic [LEN_W-1:0]                   lit_n_r, lit_n_nxt;
  logic [AW-1:0]                      idx_r, idx_nxt;
  logic                               slot_v_r, slot_v_nxt;
  logic [brle_pkg::BYTE_W-1:0]        slot_val_r, slot_val_nxt;
  logic [brle_pkg::CNT_W-1:0]         slot_cnt_r, slot_cnt_nxt;
  logic                               run2_v_r, run2_v_nxt;
  logic [brle_pkg::BYTE_W-1:0]        run2_val_r, run2_val_nxt;
  logic [brle_pkg::HDR_W-1:0]         hdr_len_r, hdr_len_nxt;
  logic [brle_pkg::HDR_W-1:0]         hdr_rem_r, hdr_rem_nxt;
  logic                               fin_r, fin_nxt;

  // segments decided by the current item
  logic [LEN_W-1:0]                   p_lit_n;
  logic                               p_slot_v;
  logic [brle_pkg::BYTE_W-1:0]        p_slot_val;
  logic [brle_pkg::CNT_W-1:0]         p_slot_cnt;
  logic                               p_run2_v;
  logic [brle_pkg::BYTE_W-1:0]        p_run2_val;

  logic                               acc_in;
  logic                               bfire;
  logic                               lit_end;
  logic [brle_pkg::BYTE_W-1:0]        b;

  assign in_ch.ready = (st_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign beat_valid  = (st_r != S_IDLE);
  assign bfire       = beat_valid && beat_ready;
  assign lit_end     = (LEN_W'(idx_r) == lit_n_r - 1'b1);
  assign mem_wdata   = b;

  // hold the read address on a stall so the registered data stays put
  assign mem_raddr = (st_r == S_LIT_BODY && bfire) ? idx_r + 1'b1 : idx_r;

  always_comb begin
    beat.data = '0;
    beat.last = 1'b0;
    unique case (st_r)
      S_LIT_HDR:  beat.data = 8'(lit_n_r - 1'b1);
      S_LIT_BODY: begin
        beat.data = mem_rdata;
        beat.last = lit_end && !slot_v_r;
      end
      S_RUN_HDR:  beat.data = brle_pkg::run_hdr_byte(slot_cnt_r, hdr_len_r, hdr_rem_r);
      S_RUN_VAL: begin
        beat.data = slot_val_r;
        beat.last = !run2_v_r;
      end
      default:    beat.data = '0;
    endcase
    beat.done = beat.last && fin_r;
  end

  always_comb begin
    mode_nxt     = mode_r;
    lit_len_nxt  = lit_len_r;
    lit_last_nxt = lit_last_r;
    run_val_nxt  = run_val_r;
    run_cnt_nxt  = run_cnt_r;
    st_nxt       = st_r;
    lit_n_nxt    = lit_n_r;
    idx_nxt      = idx_r;
    slot_v_nxt   = slot_v_r;
    slot_val_nxt = slot_val_r;
    slot_cnt_nxt = slot_cnt_r;
    run2_v_nxt   = run2_v_r;
    run2_val_nxt = run2_val_r;
    hdr_len_nxt  = hdr_len_r;
    hdr_rem_nxt  = hdr_rem_r;
    fin_nxt      = fin_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    p_lit_n      = '0;
    p_slot_v     = 1'b0;
    p_slot_val   = run_val_r;
    p_slot_cnt   = run_cnt_r;
    p_run2_v     = 1'b0;
    p_run2_val   = b;

    if (acc_in) begin
      unique case (mode_r)
        MODE_LIT: begin
          if (b == lit_last_r) begin
            // an equal pair closes the literal before it and opens a run
            if (lit_len_r >= LEN_W'(2)) begin
              p_lit_n = lit_len_r - 1'b1;
            end
            mode_nxt    = MODE_RUN;
            lit_len_nxt = '0;
            run_val_nxt = b;
            run_cnt_nxt = brle_pkg::CNT_W'(1);
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = lit_len_r[AW-1:0];
            lit_len_nxt  = lit_len_r + 1'b1;
            lit_last_nxt = b;
            if (lit_len_r + 1'b1 == LEN_MAX) begin
              p_lit_n     = LEN_MAX;
              mode_nxt    = MODE_EMPTY;
              lit_len_nxt = '0;
            end
          end
        end
        MODE_RUN: begin
          if (b == run_val_r && run_cnt_r < brle_pkg::RUN_CAP) begin
            run_cnt_nxt = run_cnt_r + 1'b1;
          end else begin
            p_slot_v     = 1'b1;
            run_cnt_nxt  = '0;
            mem_we       = 1'b1;
            mem_waddr    = '0;
            lit_len_nxt  = LEN_W'(1);
            lit_last_nxt = b;
            mode_nxt     = MODE_LIT;
          end
        end
        default: begin
          mem_we       = 1'b1;
          mem_waddr    = '0;
          lit_len_nxt  = LEN_W'(1);
          lit_last_nxt = b;
          mode_nxt     = MODE_LIT;
        end
      endcase

      // flush whatever is pending at the end of the stream
      if (in_ch.final_byte) begin
        if (mode_nxt == MODE_LIT) begin
          if (lit_len_nxt == LEN_W'(1)) begin
            // lone byte goes out as a run with no extra copies
            if (p_slot_v) begin
              p_run2_v   = 1'b1;
              p_run2_val = lit_last_nxt;
            end else begin
              p_slot_v   = 1'b1;
              p_slot_val = lit_last_nxt;
              p_slot_cnt = '0;
            end
          end else begin
            p_lit_n = lit_len_nxt;
          end
        end else if (mode_nxt == MODE_RUN) begin
          p_slot_v   = 1'b1;
          p_slot_val = run_val_nxt;
          p_slot_cnt = run_cnt_nxt;
        end
        mode_nxt    = MODE_EMPTY;
        lit_len_nxt = '0;
        run_cnt_nxt = '0;
      end

      lit_n_nxt    = p_lit_n;
      idx_nxt      = '0;
      slot_v_nxt   = p_slot_v;
      slot_val_nxt = p_slot_val;
      slot_cnt_nxt = p_slot_cnt;
      run2_v_nxt   = p_run2_v;
      run2_val_nxt = p_run2_val;
      hdr_len_nxt  = brle_pkg::run_hdr_len(p_slot_cnt);
      hdr_rem_nxt  = brle_pkg::run_hdr_len(p_slot_cnt);
      fin_nxt      = in_ch.final_byte;
      if (p_lit_n != '0) begin
        st_nxt = S_LIT_HDR;
      end else if (p_slot_v) begin
        st_nxt = S_RUN_HDR;
      end else begin
        st_nxt = S_IDLE;
      end
    end

    if (bfire) begin
      unique case (st_r)
        S_LIT_HDR: st_nxt = S_LIT_BODY;
        S_LIT_BODY: begin
          if (lit_end) begin
            st_nxt = slot_v_r ? S_RUN_HDR : S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        S_RUN_HDR: begin
          if (hdr_rem_r == 3'd1) begin
            st_nxt = S_RUN_VAL;
          end else begin
            hdr_rem_nxt = hdr_rem_r - 3'd1;
          end
        end
        S_RUN_VAL: begin
          if (run2_v_r) begin
            // advance to the trailing lone byte
            slot_val_nxt = run2_val_r;
            slot_cnt_nxt = '0;
            run2_v_nxt   = 1'b0;
            hdr_len_nxt  = 3'd1;
            hdr_rem_nxt  = 3'd1;
            st_nxt       = S_RUN_HDR;
          end else begin
            slot_v_nxt = 1'b0;
            st_nxt     = S_IDLE;
          end
        end
        default: st_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_EMPTY;
      lit_len_r <= '0;
      run_val_r <= '0;
      run_cnt_r <= '0;
      st_r      <= S_IDLE;
      slot_v_r  <= 1'b0;
      run2_v_r  <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      lit_len_r <= lit_len_nxt;
      run_val_r <= run_val_nxt;
      run_cnt_r <= run_cnt_nxt;
      st_r      <= st_nxt;
      slot_v_r  <= slot_v_nxt;
      run2_v_r  <= run2_v_nxt;
    end
    lit_last_r <= lit_last_nxt;
    lit_n_r    <= lit_n_nxt;
    idx_r      <= idx_nxt;
    slot_val_r <= slot_val_nxt;
    slot_cnt_r <= slot_cnt_nxt;
    run2_val_r <= run2_val_nxt;
    hdr_len_r  <= hdr_len_nxt;
    hdr_rem_r  <= hdr_rem_nxt;
    fin_r      <= fin_nxt;
  end

endmodule
